// ----- hw/rtl/btffa_pkg.sv -----
// Shared constants, types and sequencer states of the boundary-tag allocator.
package btffa_pkg;

    localparam int ARENA_WORDS    = 4096;
    localparam int ADDR_W         = $clog2(ARENA_WORDS);
    localparam int WORD_W         = 64;
    localparam int AW_W           = 13;
    localparam int FIELD_W        = 12;
    localparam int META_WORDS     = 6;
    localparam int HDR_WORDS      = 4;
    localparam int FTR_WORDS      = 2;
    localparam int MIN_USER_WORDS = 2;
    localparam int WALK_MAX       = ARENA_WORDS / META_WORDS;
    localparam int STEP_W         = $clog2(WALK_MAX + 2);
    localparam int MIN_AW         = 8;
    localparam logic [WORD_W-1:0] NIL_LINK = '1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_OOM     = 1'b1;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_PUT, S_DONE,
        S_A_CHK, S_A_SZ, S_A_NEXT, S_A_SPLIT, S_A_WHOLE,
        S_UNL, S_PUSH, S_MRG,
        S_F_CHK, S_F_S, S_F_FL, S_F_FT0, S_F_FT1, S_F_MARK,
        S_F_L1, S_F_L2, S_F_L3, S_F_L4, S_F_L5, S_F_L6,
        S_F_R0, S_F_R1, S_F_R2, S_F_R3, S_F_R4, S_F_R5, S_F_R6, S_F_R7
    } t_state;

    // Command from the port side to the sequencer
    typedef struct packed {
        logic               start;
        logic               mode;
        logic [FIELD_W-1:0] size_words;
        logic [FIELD_W-1:0] user_address;
        logic               cfg_we;
        logic [AW_W-1:0]    cfg_aw;
    } t_seq_cmd;

    // Status from the sequencer to the port side
    typedef struct packed {
        logic               idle;
        logic               res_valid;
        logic [FIELD_W-1:0] res_addr;
        logic               res_status;
    } t_seq_stat;

endpackage

// ----- hw/rtl/boundary_tag_first_fit_allocator_core.sv -----
// Allocate: walk the free list, checking, sizing and following each segment passed over,
// then split the found segment, take it whole, or answer out of memory.
// Free: check the tags, mark the segment free and coalesce through the arena RAM.
// One item is in work at a time; the next is taken once the result is in the output register.
// After reset and after each arena_words write all 4096 words of the arena RAM are cleared,
// one word a cycle, then the free segment's tags are laid down; no beat is taken meanwhile.
module boundary_tag_first_fit_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // size_words [11:0], user_address [23:12]
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // granted_address [11:0], zero pad [15:12]
    output logic        m_tuser,   // status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data // arena_words
);
    import btffa_pkg::*;

    t_seq_cmd           cmd;
    t_seq_stat          stat;
    logic               r_m_valid, n_m_valid;
    logic [FIELD_W-1:0] r_m_addr, n_m_addr;
    logic               r_m_st, n_m_st;
    logic [AW_W-1:0]    cfg_clamped;

    btffa_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_out_free(!r_m_valid || m_tready),
        .o_stat    (stat)
    );

    // Clamp the arena size into the supported range
    always_comb begin
        cfg_clamped = i_cfg_data;
        if (i_cfg_data < AW_W'(MIN_AW)) begin
            cfg_clamped = AW_W'(MIN_AW);
        end else if (i_cfg_data > AW_W'(ARENA_WORDS)) begin
            cfg_clamped = AW_W'(ARENA_WORDS);
        end
    end

    // Hand beats to the sequencer; configuration wins over an item
    assign o_cfg_ready = stat.idle;
    assign s_tready    = stat.idle && !i_cfg_valid;

    always_comb begin
        cmd              = '0;
        cmd.cfg_we       = i_cfg_valid && stat.idle;
        cmd.cfg_aw       = cfg_clamped;
        cmd.start        = s_tvalid && s_tready;
        cmd.mode         = s_tuser;
        cmd.size_words   = s_tdata[11:0];
        cmd.user_address = s_tdata[23:12];
    end

    // Hold the result beat until the sink takes it
    always_comb begin
        n_m_valid = r_m_valid;
        n_m_addr  = r_m_addr;
        n_m_st    = r_m_st;
        if (m_tready) begin
            n_m_valid = 1'b0;
        end
        if (stat.res_valid) begin
            n_m_valid = 1'b1;
            n_m_addr  = stat.res_addr;
            n_m_st    = stat.res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_addr <= n_m_addr;
        r_m_st   <= n_m_st;
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {4'b0, r_m_addr};
    assign m_tuser  = r_m_st;

endmodule

// ----- hw/rtl/btffa_ram.sv -----
// Single-clock RAM with one write port and one registered read port.
module btffa_ram #(
    parameter int DEPTH_W = 12,
    parameter int WIDTH   = 64
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [DEPTH_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]   i_wdata,
    input  logic [DEPTH_W-1:0] i_raddr,
    output logic [WIDTH-1:0]   o_rdata
);

    logic [WIDTH-1:0] mem [2**DEPTH_W];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

// ----- hw/rtl/btffa_seq.sv -----
// Allocator sequencer: walks the free list and edits tags through the arena RAM.
module btffa_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  btffa_pkg::t_seq_cmd i_cmd,
    input  logic                i_out_free,
    output btffa_pkg::t_seq_stat o_stat
);
    import btffa_pkg::*;

    t_state r_state, n_state, r_ret, n_ret;
    logic [2:0]          r_k, n_k;
    logic [ADDR_W-1:0]   r_cnt, n_cnt;
    logic [AW_W-1:0]     r_aw, n_aw;
    logic [AW_W-1:0]     r_head, n_head;
    logic                r_hv, n_hv;
    logic                r_oob, n_oob;
    logic                r_mode, n_mode;
    logic [FIELD_W-1:0]  r_req, n_req, r_ua, n_ua;
    logic [AW_W-1:0]     r_need, n_need;
    logic [STEP_W-1:0]   r_steps, n_steps;
    logic [WORD_W-1:0]   r_cur, n_cur, r_sz, n_sz, r_rest, n_rest, r_nh, n_nh;
    logic [WORD_W-1:0]   r_psz, n_psz;
    logic                r_pfr, n_pfr;
    logic [WORD_W-1:0]   r_h, n_h, r_s, n_s, r_tail, n_tail, r_rh, n_rh;
    logic [WORD_W-1:0]   r_lh, n_lh, r_lsz, n_lsz, r_rsz, n_rsz, r_rt, n_rt;
    logic [WORD_W-1:0]   r_t1, n_t1, r_lnk_p, n_lnk_p, r_lnk_n, n_lnk_n;
    logic [WORD_W-1:0]   r_old, n_old, r_ux, n_ux;
    logic                r_lm, n_lm, r_rm, n_rm;
    logic [FIELD_W-1:0]  r_res_addr, n_res_addr;
    logic                r_res_st, n_res_st;

    logic                mem_we;
    logic [WORD_W-1:0]   mem_wa, mem_wd, mem_ra;
    logic [WORD_W-1:0]   ram_q, q, aw64, head64, ua64;

    function automatic logic is_seg(input logic [WORD_W-1:0] v,
                                    input logic [AW_W-1:0] aw);
        return v < WORD_W'(aw);
    endfunction

    btffa_ram #(.DEPTH_W(ADDR_W), .WIDTH(WORD_W)) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we && (mem_wa[WORD_W-1:ADDR_W] == '0)),
        .i_waddr(mem_wa[ADDR_W-1:0]),
        .i_wdata(mem_wd),
        .i_raddr(mem_ra[ADDR_W-1:0]),
        .o_rdata(ram_q)
    );

    // Reads beyond the RAM's address range return zero
    assign q      = r_oob ? '0 : ram_q;
    assign aw64   = WORD_W'(r_aw);
    assign head64 = WORD_W'(r_head);
    assign ua64   = WORD_W'(r_ua);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_k     <= '0;
            r_aw    <= AW_W'(ARENA_WORDS);
            r_head  <= '0;
            r_hv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_aw    <= n_aw;
            r_head  <= n_head;
            r_hv    <= n_hv;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;       r_oob <= n_oob;     r_mode <= n_mode;
        r_req <= n_req;       r_ua <= n_ua;       r_need <= n_need;
        r_steps <= n_steps;   r_cur <= n_cur;     r_sz <= n_sz;
        r_rest <= n_rest;     r_nh <= n_nh;       r_psz <= n_psz;
        r_pfr <= n_pfr;       r_h <= n_h;         r_s <= n_s;
        r_tail <= n_tail;     r_rh <= n_rh;       r_lh <= n_lh;
        r_lsz <= n_lsz;       r_rsz <= n_rsz;     r_rt <= n_rt;
        r_t1 <= n_t1;         r_lnk_p <= n_lnk_p; r_lnk_n <= n_lnk_n;
        r_old <= n_old;       r_ux <= n_ux;       r_lm <= n_lm;
        r_rm <= n_rm;         r_res_addr <= n_res_addr;
        r_res_st <= n_res_st;
    end

    // Next state, memory commands and datapath
    always_comb begin
        n_state = r_state;  n_ret = r_ret;    n_k = r_k;        n_cnt = r_cnt;
        n_aw = r_aw;        n_head = r_head;  n_hv = r_hv;      n_mode = r_mode;
        n_req = r_req;      n_ua = r_ua;      n_need = r_need;  n_steps = r_steps;
        n_cur = r_cur;      n_sz = r_sz;      n_rest = r_rest;  n_nh = r_nh;
        n_psz = r_psz;      n_pfr = r_pfr;    n_h = r_h;        n_s = r_s;
        n_tail = r_tail;    n_rh = r_rh;      n_lh = r_lh;      n_lsz = r_lsz;
        n_rsz = r_rsz;      n_rt = r_rt;      n_t1 = r_t1;      n_lnk_p = r_lnk_p;
        n_lnk_n = r_lnk_n;  n_old = r_old;    n_ux = r_ux;      n_lm = r_lm;
        n_rm = r_rm;        n_res_addr = r_res_addr;            n_res_st = r_res_st;
        mem_we = 1'b0;  mem_wa = '0;  mem_wd = '0;  mem_ra = '0;
        o_stat = '0;

        case (r_state)
            // Sweep the whole RAM to zero, then lay down the single free segment
            S_CLR: begin
                mem_we = 1'b1;
                mem_wa = WORD_W'(r_cnt);
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_head  = '0;
                    n_hv    = 1'b1;
                    n_nh    = '0;
                    n_psz   = aw64;
                    n_pfr   = 1'b1;
                    n_ret   = S_IDLE;
                    n_k     = '0;
                    n_state = S_PUT;
                end
            end
            S_IDLE: begin
                o_stat.idle = 1'b1;
                if (i_cmd.cfg_we) begin
                    n_aw    = i_cmd.cfg_aw;
                    n_cnt   = '0;
                    n_state = S_CLR;
                end else if (i_cmd.start) begin
                    n_mode     = i_cmd.mode;
                    n_req      = i_cmd.size_words;
                    n_ua       = i_cmd.user_address;
                    n_need     = AW_W'(i_cmd.size_words) + AW_W'(META_WORDS);
                    n_cur      = r_hv ? head64 : NIL_LINK;
                    n_steps    = '0;
                    n_res_addr = '0;
                    n_res_st   = ST_OK;
                    n_state    = (i_cmd.mode == MODE_ALLOC) ? S_A_CHK : S_F_CHK;
                end
            end
            // Header then footer of segment r_nh, size r_psz, free flag r_pfr
            S_PUT: begin
                mem_we = 1'b1;
                n_k    = r_k + 1'b1;
                case (r_k)
                    3'd0: begin mem_wa = r_nh;                 mem_wd = NIL_LINK;      end
                    3'd1: begin mem_wa = r_nh + 64'd1;         mem_wd = NIL_LINK;      end
                    3'd2: begin mem_wa = r_nh + 64'd2;         mem_wd = r_psz;         end
                    3'd3: begin mem_wa = r_nh + 64'd3;         mem_wd = WORD_W'(r_pfr); end
                    3'd4: begin
                        mem_wa = r_nh + r_psz - WORD_W'(FTR_WORDS);
                        mem_wd = r_psz;
                    end
                    default: begin
                        mem_wa  = r_nh + r_psz - 64'd1;
                        mem_wd  = WORD_W'(r_pfr);
                        n_k     = '0;
                        n_state = r_ret;
                    end
                endcase
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_stat.res_valid  = 1'b1;
                    o_stat.res_addr   = r_res_addr;
                    o_stat.res_status = r_res_st;
                    n_state           = S_IDLE;
                end
            end
            // First-fit walk
            S_A_CHK: begin
                if (is_seg(r_cur, r_aw) && (r_steps <= STEP_W'(WALK_MAX))) begin
                    mem_ra  = r_cur + 64'd2;
                    n_state = S_A_SZ;
                end else begin
                    n_res_addr = '0;
                    n_res_st   = ST_OOM;
                    n_state    = S_DONE;
                end
            end
            S_A_SZ: begin
                n_sz    = q;
                n_steps = r_steps + 1'b1;
                if (q >= WORD_W'(r_need) + WORD_W'(MIN_USER_WORDS + META_WORDS)) begin
                    n_rest  = q - WORD_W'(r_need);
                    n_k     = '0;
                    n_state = S_A_SPLIT;
                end else if (q >= WORD_W'(r_need)) begin
                    n_ux    = r_cur;
                    n_ret   = S_A_WHOLE;
                    n_k     = '0;
                    n_state = S_UNL;
                end else begin
                    mem_ra  = r_cur;
                    n_state = S_A_NEXT;
                end
            end
            S_A_NEXT: begin
                n_cur   = q;
                n_state = S_A_CHK;
            end
            // Shrink the found segment and carve the tail off it
            S_A_SPLIT: begin
                mem_we = 1'b1;
                n_k    = r_k + 1'b1;
                case (r_k)
                    3'd0: begin
                        mem_wa = r_cur + 64'd2;
                        mem_wd = r_rest;
                        n_nh   = r_cur + r_rest;
                    end
                    3'd1: begin mem_wa = r_nh - WORD_W'(FTR_WORDS); mem_wd = r_rest; end
                    default: begin
                        mem_wa     = r_nh - 64'd1;
                        mem_wd     = 64'd1;
                        n_psz      = WORD_W'(r_need);
                        n_pfr      = 1'b0;
                        n_ret      = S_DONE;
                        n_res_addr = FIELD_W'(r_nh + WORD_W'(HDR_WORDS));
                        n_res_st   = ST_OK;
                        n_k        = '0;
                        n_state    = S_PUT;
                    end
                endcase
            end
            S_A_WHOLE: begin
                n_nh       = r_cur;
                n_psz      = r_sz;
                n_pfr      = 1'b0;
                n_ret      = S_DONE;
                n_res_addr = FIELD_W'(r_cur + WORD_W'(HDR_WORDS));
                n_res_st   = ST_OK;
                n_k        = '0;
                n_state    = S_PUT;
            end
            // Unlink segment r_ux from the free list
            S_UNL: begin
                n_k = r_k + 1'b1;
                case (r_k)
                    3'd0: mem_ra = r_ux;
                    3'd1: begin
                        n_lnk_n = q;
                        mem_ra  = r_ux + 64'd1;
                    end
                    3'd2: begin
                        n_lnk_p = q;
                        if (!is_seg(q, r_aw)) begin
                            n_hv   = is_seg(r_lnk_n, r_aw);
                            n_head = is_seg(r_lnk_n, r_aw) ? r_lnk_n[AW_W-1:0] : '0;
                        end else begin
                            mem_we = 1'b1;
                            mem_wa = q;
                            mem_wd = r_lnk_n;
                        end
                    end
                    default: begin
                        if (is_seg(r_lnk_n, r_aw)) begin
                            mem_we = 1'b1;
                            mem_wa = r_lnk_n + 64'd1;
                            mem_wd = r_lnk_p;
                        end
                        n_k     = '0;
                        n_state = r_ret;
                    end
                endcase
            end
            // Push segment r_ux to the front of the list
            S_PUSH: begin
                n_k = r_k + 1'b1;
                case (r_k)
                    3'd0: begin
                        mem_we = 1'b1;
                        mem_wa = r_ux;
                        mem_wd = r_hv ? head64 : NIL_LINK;
                        n_old  = r_hv ? head64 : NIL_LINK;
                    end
                    3'd1: begin
                        mem_we = 1'b1;
                        mem_wa = r_ux + 64'd1;
                        mem_wd = NIL_LINK;
                    end
                    default: begin
                        if (is_seg(r_old, r_aw)) begin
                            mem_we = 1'b1;
                            mem_wa = r_old + 64'd1;
                            mem_wd = r_ux;
                        end
                        n_head  = r_ux[AW_W-1:0];
                        n_hv    = 1'b1;
                        n_k     = '0;
                        n_state = S_DONE;
                    end
                endcase
            end
            // Merged segment takes the right neighbour's place in the list
            S_MRG: begin
                n_k = r_k + 1'b1;
                case (r_k)
                    3'd0: mem_ra = r_rh + 64'd1;
                    3'd1: begin
                        n_lnk_p = q;
                        mem_ra  = r_rh;
                    end
                    3'd2: begin
                        n_lnk_n = q;
                        if (is_seg(r_lnk_p, r_aw)) begin
                            mem_we = 1'b1;
                            mem_wa = r_lnk_p;
                            mem_wd = r_h;
                        end else begin
                            n_head = r_h[AW_W-1:0];
                            n_hv   = 1'b1;
                        end
                    end
                    3'd3: begin
                        if (is_seg(r_lnk_n, r_aw)) begin
                            mem_we = 1'b1;
                            mem_wa = r_lnk_n + 64'd1;
                            mem_wd = r_h;
                        end
                    end
                    3'd4: begin
                        mem_we = 1'b1;
                        mem_wa = r_h;
                        mem_wd = r_lnk_n;
                    end
                    default: begin
                        mem_we  = 1'b1;
                        mem_wa  = r_h + 64'd1;
                        mem_wd  = r_lnk_p;
                        n_k     = '0;
                        n_state = S_DONE;
                    end
                endcase
            end
            // Check that the freed header is a well-formed allocated segment
            S_F_CHK: begin
                if (r_ua < FIELD_W'(HDR_WORDS)) begin
                    n_state = S_DONE;
                end else if (ua64 - WORD_W'(HDR_WORDS) >= aw64) begin
                    n_state = S_DONE;
                end else begin
                    n_h     = ua64 - WORD_W'(HDR_WORDS);
                    mem_ra  = ua64 - 64'd2;
                    n_state = S_F_S;
                end
            end
            S_F_S: begin
                n_s = q;
                if (q < WORD_W'(META_WORDS) || q > aw64 - r_h) begin
                    n_state = S_DONE;
                end else begin
                    mem_ra  = r_h + 64'd3;
                    n_state = S_F_FL;
                end
            end
            S_F_FL: begin
                n_tail = r_h + r_s - WORD_W'(FTR_WORDS);
                n_rh   = r_h + r_s;
                if (q != '0) begin
                    n_state = S_DONE;
                end else begin
                    mem_ra  = r_h + r_s - WORD_W'(FTR_WORDS);
                    n_state = S_F_FT0;
                end
            end
            S_F_FT0: begin
                if (q != r_s) begin
                    n_state = S_DONE;
                end else begin
                    mem_ra  = r_tail + 64'd1;
                    n_state = S_F_FT1;
                end
            end
            S_F_FT1: begin
                if (q != '0) begin
                    n_state = S_DONE;
                end else begin
                    mem_we  = 1'b1;
                    mem_wa  = r_h + 64'd3;
                    mem_wd  = 64'd1;
                    n_state = S_F_MARK;
                end
            end
            S_F_MARK: begin
                mem_we = 1'b1;
                mem_wa = r_tail + 64'd1;
                mem_wd = 64'd1;
                n_lm   = 1'b0;
                n_rm   = 1'b0;
                if (r_h >= WORD_W'(FTR_WORDS)) begin
                    mem_ra  = r_h - 64'd1;
                    n_state = S_F_L1;
                end else begin
                    n_state = S_F_R0;
                end
            end
            // Coalesce with a free left neighbour
            S_F_L1: begin
                if (q != '0) begin
                    mem_ra  = r_h - WORD_W'(FTR_WORDS);
                    n_state = S_F_L2;
                end else begin
                    n_state = S_F_R0;
                end
            end
            S_F_L2: begin
                n_lsz   = q;
                n_lh    = r_h - q;
                n_state = S_F_L3;
            end
            S_F_L3: begin
                mem_ra  = r_lh + 64'd2;
                n_state = S_F_L4;
            end
            S_F_L4: begin
                mem_we  = 1'b1;
                mem_wa  = r_lh + 64'd2;
                mem_wd  = q + r_s;
                n_state = S_F_L5;
            end
            S_F_L5: begin
                mem_ra  = r_tail;
                n_state = S_F_L6;
            end
            S_F_L6: begin
                mem_we  = 1'b1;
                mem_wa  = r_tail;
                mem_wd  = q + r_lsz;
                n_h     = r_lh;
                n_lm    = 1'b1;
                n_state = S_F_R0;
            end
            // Coalesce with a free right neighbour
            S_F_R0: begin
                if (r_rh < aw64) begin
                    mem_ra  = r_rh + 64'd3;
                    n_state = S_F_R1;
                end else begin
                    n_state = S_F_R7;
                    n_k     = '1;
                end
            end
            S_F_R1: begin
                if (q != '0) begin
                    mem_ra  = r_rh + 64'd2;
                    n_state = S_F_R2;
                end else begin
                    n_state = S_F_R7;
                    n_k     = '1;
                end
            end
            S_F_R2: begin
                n_rsz   = q;
                n_rt    = r_rh + q - WORD_W'(FTR_WORDS);
                n_state = S_F_R3;
            end
            S_F_R3: begin
                mem_ra  = r_rt;
                n_state = S_F_R4;
            end
            S_F_R4: begin
                n_t1    = q;
                mem_ra  = r_h + 64'd2;
                n_state = S_F_R5;
            end
            S_F_R5: begin
                mem_we  = 1'b1;
                mem_wa  = r_rt;
                mem_wd  = r_t1 + q;
                n_state = S_F_R6;
            end
            S_F_R6: begin
                mem_ra  = r_h + 64'd2;
                n_k     = '0;
                n_state = S_F_R7;
            end
            // Write back the grown size (skipped when r_k is all ones), then relink
            S_F_R7: begin
                if (r_k == '0) begin
                    mem_we = 1'b1;
                    mem_wa = r_h + 64'd2;
                    mem_wd = q + r_rsz;
                    n_rm   = 1'b1;
                end
                n_k = '0;
                case ({r_lm, (r_k == '0) ? 1'b1 : r_rm})
                    2'b00: begin
                        n_ux    = r_h;
                        n_state = S_PUSH;
                    end
                    2'b01: n_state = S_MRG;
                    2'b11: begin
                        n_ux    = r_rh;
                        n_ret   = S_F_L1;
                        n_state = S_UNL;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            default: n_state = S_IDLE;
        endcase

        // After the right unlink of a double merge, unlink the left one and push it
        if (r_state == S_UNL && r_k == 3'd3 && r_ret == S_F_L1) begin
            n_ux    = r_lh;
            n_ret   = S_PUSH;
            n_state = S_UNL;
        end

        n_oob = (mem_ra[WORD_W-1:ADDR_W] != '0);
    end

endmodule
